@@ rtl/szel_pkg.sv @@
`default_nettype none

package szel_pkg;

	localparam int ZONES     = 16;
	localparam int ZONE_BITS = 4;
	localparam int RAD_BITS  = 16;
	localparam int RSQ_BITS  = 2 * RAD_BITS;

	localparam logic [1:0] CMD_SET    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;

	localparam logic EV_ENTER = 1'b0;
	localparam logic EV_LEAVE = 1'b1;

	// Pipeline token: a zone to check, or the end-of-scan marker
	typedef struct packed {
		logic v;
		logic flush;
	} tok_t;

	typedef struct packed {
		logic [ZONE_BITS-1:0] zone;
		logic                 kind;
	} evt_t;

endpackage

`default_nettype wire

@@ rtl/sphere_zone_enter_leave.sv @@
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  command, zone, pos_x, pos_y, pos_z, zone_radius
// output    out        out_valid/out_stall  event_zone, event_kind, last_event
//
// Set and remove transactions never raise in_stall. A report transaction scans every
// slot, one read of the zone memory per cycle, and in_stall stays high until the
// end-of-scan marker, issued after the last slot, has passed the four stages of
// memory read, difference, square and sum. Reset clears the valid and inside flags
// at once; the zone memory needs no clearing. A stalled output freezes the scan.
module sphere_zone_enter_leave
	import szel_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   command,
	input  wire logic [ZONE_BITS-1:0]         zone,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	input  wire logic signed [COORD_BITS-1:0] pos_z,
	input  wire logic [RAD_BITS-1:0]          zone_radius,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ZONE_BITS-1:0]              event_zone,
	output logic                              event_kind,
	output logic                              last_event
);

	localparam int ZW    = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int CW    = $clog2(ZONES + 1);
	localparam int DSW   = 4 * (COORD_BITS + 1);
	localparam int CMPW  = (DSW > RSQ_BITS) ? DSW : RSQ_BITS;
	localparam int MEMW  = 3 * COORD_BITS + RAD_BITS;

	logic                  busy_q, issuing_q;
	logic [CW-1:0]         cnt_q;
	logic [ZW-1:0]         cnt_idx;
	logic [ZONES-1:0]      valid_q, inside_q;
	logic [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic                  accept, slot_ok, do_set, do_remove, adv, ram_re, scan_end;
	logic [ZW-1:0]         wa;
	logic [MEMW-1:0]       rd_s1;
	tok_t                  tok_s1, tok_s4;
	logic [ZW-1:0]         idx_s1, idx_s4;
	logic [DSW-1:0]        dsq_s4;
	logic [RSQ_BITS-1:0]   rsq_s4;
	logic [CMPW-1:0]       dsq_c, rsq_c;
	logic                  in_now, ev_v;
	evt_t                  evt;

	assign in_stall  = busy_q;
	assign accept    = in_valid && !in_stall;
	assign slot_ok   = int'(zone) < ZONES;
	assign wa        = ZW'(zone);
	assign do_set    = accept && (command == CMD_SET) && slot_ok;
	assign do_remove = accept && (command == CMD_REMOVE) && slot_ok;
	assign cnt_idx   = cnt_q[ZW-1:0];
	assign scan_end  = (cnt_q == CW'(ZONES));
	assign ram_re    = adv && issuing_q && !scan_end;

	szel_ram #(
		.WIDTH(MEMW),
		.DEPTH(ZONES)
	) u_zone_ram (
		.clk  (clk),
		.we   (do_set),
		.waddr(wa),
		.wdata({pos_x, pos_y, pos_z, zone_radius}),
		.re   (ram_re),
		.raddr(cnt_idx),
		.rdata(rd_s1)
	);

	// Issue stage: walk the slots, then send the end-of-scan marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			cnt_q     <= '0;
			tok_s1    <= '0;
		end else begin
			if (accept && (command == CMD_REPORT)) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				cnt_q     <= '0;
			end else if (adv && tok_s4.flush) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				if (issuing_q) begin
					if (scan_end) begin
						tok_s1    <= '{v: 1'b0, flush: 1'b1};
						issuing_q <= 1'b0;
					end else begin
						tok_s1 <= '{v: valid_q[cnt_idx], flush: 1'b0};
						cnt_q  <= cnt_q + CW'(1);
					end
				end else begin
					tok_s1 <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_REPORT)) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
		end
		if (ram_re) begin
			idx_s1 <= cnt_idx;
		end
	end

	szel_dist #(
		.COORD_BITS(COORD_BITS),
		.ZW        (ZW)
	) u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.tok_s1(tok_s1),
		.idx_s1(idx_s1),
		.cx_s1 (rd_s1[MEMW-1 -: COORD_BITS]),
		.cy_s1 (rd_s1[MEMW-COORD_BITS-1 -: COORD_BITS]),
		.cz_s1 (rd_s1[RAD_BITS +: COORD_BITS]),
		.r_s1  (rd_s1[RAD_BITS-1:0]),
		.px    (px_q),
		.py    (py_q),
		.pz    (pz_q),
		.tok_s4(tok_s4),
		.idx_s4(idx_s4),
		.dsq_s4(dsq_s4),
		.rsq_s4(rsq_s4)
	);

	// Decide membership change; equality leaves the zone as it is
	assign dsq_c  = CMPW'(dsq_s4);
	assign rsq_c  = CMPW'(rsq_s4);
	assign in_now = inside_q[idx_s4];
	assign ev_v   = tok_s4.v && !tok_s4.flush &&
		((!in_now && (dsq_c < rsq_c)) || (in_now && (dsq_c > rsq_c)));
	assign evt.zone = ZONE_BITS'(idx_s4);
	assign evt.kind = in_now ? EV_LEAVE : EV_ENTER;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			inside_q <= '0;
		end else begin
			if (do_set) begin
				valid_q[wa]  <= 1'b1;
				inside_q[wa] <= 1'b0;
			end else if (do_remove) begin
				valid_q[wa]  <= 1'b0;
				inside_q[wa] <= 1'b0;
			end else if (adv && ev_v) begin
				inside_q[idx_s4] <= !in_now;
			end
		end
	end

	szel_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && ev_v),
		.evt       (evt),
		.fin       (adv && tok_s4.flush),
		.out_stall (out_stall),
		.out_free  (adv),
		.out_valid (out_valid),
		.event_zone(event_zone),
		.event_kind(event_kind),
		.last_event(last_event)
	);

endmodule

`default_nettype wire

@@ rtl/szel_ram.sv @@
`default_nettype none

module szel_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/szel_dist.sv @@
`default_nettype none

module szel_dist
	import szel_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int ZW         = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire tok_t                         tok_s1,
	input  wire logic [ZW-1:0]                idx_s1,
	input  wire logic [COORD_BITS-1:0]        cx_s1,
	input  wire logic [COORD_BITS-1:0]        cy_s1,
	input  wire logic [COORD_BITS-1:0]        cz_s1,
	input  wire logic [RAD_BITS-1:0]          r_s1,
	input  wire logic [COORD_BITS-1:0]        px,
	input  wire logic [COORD_BITS-1:0]        py,
	input  wire logic [COORD_BITS-1:0]        pz,
	output tok_t                              tok_s4,
	output logic [ZW-1:0]                     idx_s4,
	output logic [2*(2*(COORD_BITS+1))-1:0]   dsq_s4,
	output logic [RSQ_BITS-1:0]               rsq_s4
);

	localparam int DW  = COORD_BITS + 1;
	localparam int SQW = 2 * DW;
	localparam int DSW = 2 * SQW;

	tok_t                   tok_s2, tok_s3;
	logic [ZW-1:0]          idx_s2, idx_s3;
	logic signed [DW-1:0]   dx_s2, dy_s2, dz_s2;
	logic [RAD_BITS-1:0]    r_s2;
	logic signed [SQW-1:0]  px2, py2, pz2;
	logic [SQW-1:0]         sqx_s3, sqy_s3, sqz_s3;
	logic [RSQ_BITS-1:0]    rsq_s3;

	assign px2 = dx_s2 * dx_s2;
	assign py2 = dy_s2 * dy_s2;
	assign pz2 = dz_s2 * dz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
			tok_s3 <= '0;
			tok_s4 <= '0;
		end else if (adv) begin
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
			tok_s4 <= tok_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// difference, then squares, then sum
			idx_s2 <= idx_s1;
			dx_s2  <= DW'($signed(cx_s1)) - DW'($signed(px));
			dy_s2  <= DW'($signed(cy_s1)) - DW'($signed(py));
			dz_s2  <= DW'($signed(cz_s1)) - DW'($signed(pz));
			r_s2   <= r_s1;

			idx_s3 <= idx_s2;
			sqx_s3 <= $unsigned(px2);
			sqy_s3 <= $unsigned(py2);
			sqz_s3 <= $unsigned(pz2);
			rsq_s3 <= r_s2 * r_s2;

			idx_s4 <= idx_s3;
			dsq_s4 <= DSW'(sqx_s3) + DSW'(sqy_s3) + DSW'(sqz_s3);
			rsq_s4 <= rsq_s3;
		end
	end

endmodule

`default_nettype wire

@@ rtl/szel_evq.sv @@
`default_nettype none

module szel_evq
	import szel_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire evt_t                 evt,
	input  wire logic                 fin,
	input  wire logic                 out_stall,
	output logic                      out_free,
	output logic                      out_valid,
	output logic [ZONE_BITS-1:0]      event_zone,
	output logic                      event_kind,
	output logic                      last_event
);

	logic pend_v_q;
	evt_t pend_q;
	logic emit;

	// hold one event back until the next one or the end of scan settles its last flag
	assign emit     = (push || fin) && pend_v_q;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (push) begin
				pend_v_q <= 1'b1;
			end else if (fin) begin
				pend_v_q <= 1'b0;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= evt;
		end
		if (emit) begin
			event_zone <= pend_q.zone;
			event_kind <= pend_q.kind;
			last_event <= fin;
		end
	end

endmodule

`default_nettype wire
